FILE: src/assert_macros.svh
// Assertion macros used by the decoder top level.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

FILE: src/csd_pkg.sv
// Types and constants of the CAN signal decoder.
// No dependencies.
package csd_pkg;
    localparam int ID_W     = 29;
    localparam int RAW_W    = 64;
    localparam int SCALE_W  = 32;
    localparam int OFFSET_W = 48;
    localparam logic [7:0] BYTE_MASK = 8'hff;

    typedef enum logic {OP_LOAD = 1'b0, OP_DECODE = 1'b1} opcode_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [2:0]      total;
        logic            big;
    } entry_t;

    typedef struct packed {
        logic [2:0]          start;
        logic [2:0]          stop;
        logic [SCALE_W-1:0]  scale;
        logic [OFFSET_W-1:0] offset;
    } sig_desc_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_SIG_RD, ST_GATHER, ST_MUL, ST_SUM, ST_OUT
    } state_t;

    // request handed from the sequencer to the arithmetic unit
    typedef struct packed {
        logic            go;
        logic [63:0]     data;
        logic            big;
        sig_desc_t       desc;
    } calc_req_t;

    typedef struct packed {
        logic [63:0] raw;
        logic [63:0] phys;
        logic        sat;
    } calc_res_t;

    // gather start..stop bytes; one pass over eight independent bytes
    function automatic logic [63:0] gather(input logic [63:0] d, input logic [2:0] s,
                                           input logic [2:0] e, input logic big);
        logic [63:0] r;
        logic [2:0]  pos;
        r = '0;
        if (e >= s) begin
            for (int i = 0; i < 8; i++) begin
                if (3'(i) >= s && 3'(i) <= e) begin
                    pos = big ? 3'(e - 3'(i)) : 3'(3'(i) - s);
                    r[pos*8 +: 8] = d[i*8 +: 8] & BYTE_MASK;
                end
            end
        end
        return r;
    endfunction
endpackage

FILE: src/csd_calc.sv
// Raw gathering and offset + scale * raw with 64-bit saturation.
// Depends on csd_pkg. Three stages (gather, two 32x32 products, sum); done marks the registered sum.
module csd_calc (
    input  logic                aclk,
    input  logic                aresetn,
    input  csd_pkg::calc_req_t  req,
    output logic                done,
    output csd_pkg::calc_res_t  res
);
    logic [63:0]  raw_reg;
    logic [31:0]  mag_reg;
    logic         neg_reg;
    logic [47:0]  off_reg;
    logic [63:0]  plo_reg, phi_reg;
    logic [3:0]   vld_reg;
    logic [63:0]  phys_reg;
    logic         sat_reg;
    logic [95:0]  prod;
    logic [128:0] sum;
    logic [128:0] sprod;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else vld_reg <= {vld_reg[2:0], req.go};
        if (req.go) begin
            raw_reg <= csd_pkg::gather(req.data, req.desc.start, req.desc.stop, req.big);
            neg_reg <= req.desc.scale[31];
            mag_reg <= req.desc.scale[31] ? 32'(-req.desc.scale) : req.desc.scale;
            off_reg <= req.desc.offset;
        end
        if (vld_reg[0]) begin
            plo_reg <= 64'(raw_reg[31:0]) * 64'(mag_reg);
            phi_reg <= 64'(raw_reg[63:32]) * 64'(mag_reg);
        end
        if (vld_reg[1]) begin
            phys_reg <= (sum[128:63] == '0 || sum[128:63] == '1) ? sum[63:0] :
                        (sum[128] ? 64'h8000000000000000 : 64'h7fffffffffffffff);
            sat_reg  <= !(sum[128:63] == '0 || sum[128:63] == '1);
        end
    end

    always_comb begin
        prod  = 96'(plo_reg) + {phi_reg, 32'h0};
        sprod = neg_reg ? 129'(-{33'h0, prod}) : {33'h0, prod};
        sum   = sprod + {{81{off_reg[47]}}, off_reg};
    end

    assign done = vld_reg[2];
    assign res  = '{raw: raw_reg, phys: phys_reg, sat: sat_reg};
endmodule

FILE: src/csd_table.sv
// Descriptor table: entry memory and signal memory, registered read.
// Depends on csd_pkg.
module csd_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_SIGNALS = 4
) (
    input  logic                                      aclk,
    input  logic                                      e_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]            e_addr,
    input  csd_pkg::entry_t                           e_wdata,
    output csd_pkg::entry_t                           e_rdata,
    input  logic                                      s_we,
    input  logic [$clog2(TABLE_DEPTH*MAX_SIGNALS)-1:0] s_addr,
    input  csd_pkg::sig_desc_t                        s_wdata,
    output csd_pkg::sig_desc_t                        s_rdata
);
    csd_pkg::entry_t    emem [TABLE_DEPTH];
    csd_pkg::sig_desc_t smem [TABLE_DEPTH*MAX_SIGNALS];

    always_ff @(posedge aclk) begin
        if (e_we) emem[e_addr] <= e_wdata;
        e_rdata <= emem[e_addr];
    end
    always_ff @(posedge aclk) begin
        if (s_we) smem[s_addr] <= s_wdata;
        s_rdata <= smem[s_addr];
    end
endmodule

FILE: src/can_signal_decoder_top.sv
// Top level of the CAN signal decoder: sequencer, table, arithmetic.
// Depends on csd_pkg, csd_table, csd_calc, assert_macros.svh.
// Load: accepted in ST_IDLE, s_tready is high again on the next cycle.
// Decode: accept, a scan of every entry-memory address, then per signal the steps
// read, gather, arithmetic and output; an output stall holds the output step until
// m_tready. Reset clears the live flags at once, no sweep.
`include "assert_macros.svh"
module can_signal_decoder_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_SIGNALS = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, entry_index[6], signal_slot[2], can_id[29], sig_total[3],
    // byte_order, first_byte[3], last_byte[3], scale_q16[32], offset_q16[48],
    // frame_data[64], timestamp_us[64]; 256 bits
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // matched_entry[6], signal_index[2], raw_value[64], phys_val[64],
    // saturated, frame_time_us[64]; 208 bits
    output logic [207:0] m_tdata,
    output logic         m_tlast
);
    localparam int EW = $clog2(TABLE_DEPTH);
    localparam int AW = $clog2(TABLE_DEPTH*MAX_SIGNALS);

    logic        in_op;
    logic [5:0]  in_entry;
    logic [1:0]  in_slot;
    logic [28:0] in_id;
    logic [2:0]  in_cnt;
    logic        in_big;
    csd_pkg::sig_desc_t in_desc;
    assign in_op    = s_tdata[0];
    assign in_entry = s_tdata[6:1];
    assign in_slot  = s_tdata[8:7];
    assign in_id    = s_tdata[37:9];
    assign in_cnt   = s_tdata[40:38];
    assign in_big   = s_tdata[41];
    assign in_desc  = '{start: s_tdata[44:42], stop: s_tdata[47:45],
                        scale: s_tdata[79:48], offset: s_tdata[127:80]};

    // Count 0 / valid bits live in flip-flops: non-zero count marks a live entry.
    logic [TABLE_DEPTH-1:0] live_reg, live_next;
    csd_pkg::state_t state_reg, state_next;
    logic [EW:0]   scan_reg, scan_next;
    logic          found_reg, found_next;
    logic [EW-1:0] hit_reg, hit_next;
    logic [2:0]    total_reg, total_next;
    logic          big_reg, big_next;
    logic [3:0]    k_reg, k_next;
    logic [28:0]   id_reg;
    logic [63:0]   data_reg, ts_reg;
    logic          rd_pend_reg;
    logic [EW-1:0] rd_idx_reg;
    logic          out_v_reg;
    logic [207:0]  out_d_reg;
    logic          out_l_reg;

    logic e_we, s_we;
    logic [EW-1:0] e_addr;
    logic [AW-1:0] s_addr;
    csd_pkg::entry_t e_wdata, e_rdata;
    csd_pkg::sig_desc_t s_rdata;
    csd_pkg::calc_req_t creq;
    csd_pkg::calc_res_t cres;
    logic cdone;
    logic accept;
    logic load_ok;
    logic [2:0] cnt_sat;

    assign accept  = s_tvalid && s_tready;
    assign load_ok = (32'(in_entry) < TABLE_DEPTH) && (32'(in_slot) < MAX_SIGNALS);
    assign cnt_sat = (32'(in_cnt) > MAX_SIGNALS) ? 3'(MAX_SIGNALS) : in_cnt;

    csd_table #(.TABLE_DEPTH(TABLE_DEPTH), .MAX_SIGNALS(MAX_SIGNALS)) u_table (
        .aclk, .e_we, .e_addr, .e_wdata, .e_rdata,
        .s_we, .s_addr, .s_wdata(in_desc), .s_rdata
    );
    csd_calc u_calc (.aclk, .aresetn, .req(creq), .done(cdone), .res(cres));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= csd_pkg::ST_IDLE;
            live_reg    <= '0;
            rd_pend_reg <= 1'b0;
            out_v_reg   <= 1'b0;
            found_reg   <= 1'b0;
            scan_reg    <= '0;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            found_reg   <= found_next;
            scan_reg    <= scan_next;
            k_reg       <= k_next;
            rd_pend_reg <= (state_reg == csd_pkg::ST_SCAN) && !scan_reg[EW];
            if (cdone) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
        end
        hit_reg    <= hit_next;
        total_reg  <= total_next;
        big_reg    <= big_next;
        rd_idx_reg <= scan_reg[EW-1:0];
        if (accept && in_op == csd_pkg::OP_DECODE) begin
            id_reg   <= in_id;
            data_reg <= s_tdata[191:128];
            ts_reg   <= s_tdata[255:192];
        end
        if (cdone) begin
            out_d_reg <= {7'd0, ts_reg, cres.sat, cres.phys, cres.raw, 2'(k_reg - 4'd1),
                          6'(hit_reg)};
            out_l_reg <= (k_reg == 4'(total_reg));
        end
    end

    always_comb begin
        state_next = state_reg;
        live_next  = live_reg;
        scan_next  = scan_reg;
        found_next = found_reg;
        hit_next   = hit_reg;
        total_next = total_reg;
        big_next   = big_reg;
        k_next     = k_reg;
        s_tready   = 1'b0;
        e_we       = 1'b0;
        s_we       = 1'b0;
        e_addr     = scan_reg[EW-1:0];
        s_addr     = AW'(hit_reg) * AW'(MAX_SIGNALS) + AW'(k_reg);
        e_wdata    = '{id: in_id, total: cnt_sat, big: in_big};
        creq       = '{go: 1'b0, data: data_reg, big: big_reg, desc: s_rdata};
        // a hit from the previous read, compared in the cycle after its address
        if (rd_pend_reg && live_reg[rd_idx_reg] && e_rdata.id == id_reg) begin
            found_next = 1'b1;
            hit_next   = rd_idx_reg;
            total_next = e_rdata.total;
            big_next   = e_rdata.big;
        end
        unique case (state_reg)
            csd_pkg::ST_IDLE: begin
                s_tready = aresetn;
                e_addr   = EW'(in_entry);
                s_addr   = AW'(in_entry) * AW'(MAX_SIGNALS) + AW'(in_slot);
                if (accept) begin
                    if (in_op == csd_pkg::OP_LOAD) begin
                        if (load_ok) begin
                            e_we = 1'b1;
                            s_we = 1'b1;
                            live_next[EW'(in_entry)] = (cnt_sat != 3'd0);
                        end
                    end else begin
                        scan_next  = '0;
                        found_next = 1'b0;
                        state_next = csd_pkg::ST_SCAN;
                    end
                end
            end
            csd_pkg::ST_SCAN: begin
                if (!scan_reg[EW]) scan_next = scan_reg + 1'b1;
                else if (!rd_pend_reg) begin
                    k_next = '0;
                    state_next = found_reg ? csd_pkg::ST_SIG_RD : csd_pkg::ST_IDLE;
                end
            end
            csd_pkg::ST_SIG_RD: state_next = csd_pkg::ST_GATHER;
            csd_pkg::ST_GATHER: begin
                creq.go    = 1'b1;
                k_next     = k_reg + 4'd1;
                state_next = csd_pkg::ST_MUL;
            end
            csd_pkg::ST_MUL: if (cdone) state_next = csd_pkg::ST_OUT;
            csd_pkg::ST_SUM: state_next = csd_pkg::ST_OUT;
            csd_pkg::ST_OUT: begin
                if (!out_v_reg || m_tready)
                    state_next = (k_reg == 4'(total_reg)) ? csd_pkg::ST_IDLE
                                                          : csd_pkg::ST_SIG_RD;
            end
            default: state_next = csd_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tlast  = out_l_reg;

    `ASSERT_IMPL(a_busy_no_ready, aclk, aresetn,
        (state_reg != csd_pkg::ST_IDLE) |-> !s_tready)
    `ASSERT_IMPL(a_calc_one, aclk, aresetn,
        cdone |-> (state_reg == csd_pkg::ST_MUL))
    `ASSERT_NEVER(a_k_bound, aclk, aresetn, k_reg > 4'(MAX_SIGNALS))
endmodule

FILE: test/tb.sv
// Self-checking testbench for can_signal_decoder_top: loads descriptor tables,
// decodes frames and checks every signal result against an in-bench predictor.
// Depends on csd_pkg and the decoder RTL only.
module tb;
    localparam int N_ENTRY     = 64;
    localparam int N_SLOT      = 4;
    localparam int WDOG_LIMIT  = 20000;
    localparam int DRAIN_TAIL  = 200;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        csd_pkg::opcode_t op;
        logic [5:0]   entry;
        logic [1:0]   slot;
        logic [28:0]  id;
        logic [2:0]   count;
        logic         big;
        logic [2:0]   start;
        logic [2:0]   stop;
        logic [31:0]  scale;
        logic [47:0]  offset;
        logic [63:0]  data;
        logic [63:0]  stamp;
        bit           drain;   // wait for all results before offering
        bit           burst;   // no idle gap after this request
    } request_t;

    typedef struct {
        logic [5:0]  entry;
        logic [1:0]  idx;
        logic [63:0] raw;
        logic [63:0] phys;
        logic        sat;
        logic [63:0] stamp;
        logic        last;
    } signal_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;
    logic         m_tlast;

    can_signal_decoder_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    request_t    pending_q[$];
    signal_res_t decoded_q[$];

    // predictor copy of the descriptor table
    logic [28:0] tbl_id[N_ENTRY];
    logic [2:0]  tbl_cnt[N_ENTRY];
    logic        tbl_big[N_ENTRY];
    csd_pkg::sig_desc_t tbl_sig[N_ENTRY][N_SLOT];

    // generator view of which slots hold a descriptor
    bit          slot_loaded[N_ENTRY][N_SLOT];
    logic [28:0] id_pool[10];

    int errors = 0;
    int n_loads = 0, n_decodes = 0, n_results = 0, n_sat = 0, n_nomatch = 0;
    int idle_cycles = 0;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic logic [63:0] assemble_raw(input logic [63:0] d, input logic [2:0] s,
                                                 input logic [2:0] e, input logic big);
        logic [63:0] r;
        int pos;
        r = '0;
        if (e >= s)
            for (int i = s; i <= e; i++) begin
                pos = big ? (e - i) : (i - s);
                r = r | ({56'd0, d[i*8 +: 8]} << (pos * 8));
            end
        return r;
    endfunction

    task automatic predict_decode(input request_t r);
        int hit;
        signal_res_t res;
        logic signed [127:0] acc;
        hit = -1;
        for (int e = 0; e < N_ENTRY; e++)
            if (tbl_cnt[e] != 0 && tbl_id[e] == r.id) hit = e;
        if (hit < 0) begin
            n_nomatch++;
            return;
        end
        for (int k = 0; k < tbl_cnt[hit]; k++) begin
            res.entry = 6'(hit);
            res.idx   = 2'(k);
            res.raw   = assemble_raw(r.data, tbl_sig[hit][k].start, tbl_sig[hit][k].stop,
                                     tbl_big[hit]);
            acc = $signed({{96{tbl_sig[hit][k].scale[31]}}, tbl_sig[hit][k].scale})
                * $signed({64'd0, res.raw})
                + $signed({{80{tbl_sig[hit][k].offset[47]}}, tbl_sig[hit][k].offset});
            if (acc[127:63] == '0 || acc[127:63] == '1) begin
                res.phys = acc[63:0];
                res.sat  = 1'b0;
            end else begin
                res.phys = acc[127] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
                res.sat  = 1'b1;
            end
            res.stamp = r.stamp;
            res.last  = (k + 1 == tbl_cnt[hit]);
            decoded_q.push_back(res);
        end
    endtask

    task automatic predict_request(input request_t r);
        if (r.op == csd_pkg::OP_LOAD) begin
            n_loads++;
            tbl_id[r.entry]  = r.id;
            tbl_cnt[r.entry] = r.count > 3'd4 ? 3'd4 : r.count;
            tbl_big[r.entry] = r.big;
            tbl_sig[r.entry][r.slot] = '{start: r.start, stop: r.stop,
                                        scale: r.scale, offset: r.offset};
        end else begin
            n_decodes++;
            predict_decode(r);
        end
    endtask

    function automatic logic [255:0] pack_request(input request_t r);
        return {r.stamp, r.data, r.offset, r.scale, r.stop, r.start, r.big, r.count,
                r.id, r.slot, r.entry, logic'(r.op)};
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 19);
        if (p < 11) return 0;
        if (p < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- driver ----------------
    request_t cur_req;
    bit       cur_busy = 0;
    int       send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_request(cur_req);
                cur_busy = 0;
                send_gap = cur_req.burst ? 0 : pick_gap();
            end
            if (!cur_busy && send_gap > 0)
                send_gap--;
            else if (!cur_busy && pending_q.size() > 0 &&
                     !(pending_q[0].drain && decoded_q.size() != 0)) begin
                cur_req  = pending_q.pop_front();
                cur_busy = 1;
                s_tdata <= pack_request(cur_req);
            end
            s_tvalid <= cur_busy;
        end
    end

    // ---------------- receiver and checker ----------------
    int  rx_stall = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    signal_res_t exp_res;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (decoded_q.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    exp_res = decoded_q.pop_front();
                    if (m_tdata[5:0] !== exp_res.entry)
                        report($sformatf("matched_entry %0d exp %0d", m_tdata[5:0], exp_res.entry));
                    if (m_tdata[7:6] !== exp_res.idx)
                        report($sformatf("signal_index %0d exp %0d", m_tdata[7:6], exp_res.idx));
                    if (m_tdata[71:8] !== exp_res.raw)
                        report($sformatf("raw_value %h exp %h", m_tdata[71:8], exp_res.raw));
                    if (m_tdata[135:72] !== exp_res.phys)
                        report($sformatf("phys value %h exp %h", m_tdata[135:72],
                                         exp_res.phys));
                    if (m_tdata[136] !== exp_res.sat)
                        report($sformatf("saturated %b exp %b", m_tdata[136], exp_res.sat));
                    if (m_tdata[200:137] !== exp_res.stamp)
                        report($sformatf("frame_time_us %h exp %h", m_tdata[200:137],
                                         exp_res.stamp));
                    if (m_tlast !== exp_res.last)
                        report($sformatf("tlast %b exp %b", m_tlast, exp_res.last));
                    if (exp_res.sat) n_sat++;
                end
            end
            // one long back-pressure window once results are flowing
            if (!hold_done && n_results >= 20) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                rx_stall = pick_gap();
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", WDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic int ready_slots(input int e);
        int n;
        n = 0;
        while (n < N_SLOT && slot_loaded[e][n]) n++;
        return n;
    endfunction

    task automatic add_load(input int e, input int slot, input logic [28:0] id,
                            input logic [2:0] cnt, input logic big, input logic [2:0] s,
                            input logic [2:0] t, input logic [31:0] sc,
                            input logic [47:0] off, input bit burst = 0);
        request_t r;
        r = '{op: csd_pkg::OP_LOAD, entry: 6'(e), slot: 2'(slot), id: id, count: cnt,
              big: big, start: s, stop: t, scale: sc, offset: off,
              data: {$urandom, $urandom}, stamp: {$urandom, $urandom},
              drain: 0, burst: burst};
        slot_loaded[e][slot] = 1;
        pending_q.push_back(r);
    endtask

    task automatic add_decode(input logic [28:0] id, input logic [63:0] d,
                              input logic [63:0] ts, input bit drain = 0, input bit burst = 0);
        request_t r;
        r = '{op: csd_pkg::OP_DECODE, entry: 6'($urandom), slot: 2'($urandom), id: id,
              count: 3'($urandom), big: 1'($urandom), start: 3'($urandom),
              stop: 3'($urandom), scale: $urandom, offset: 48'({$urandom, $urandom}),
              data: d, stamp: ts, drain: drain, burst: burst};
        pending_q.push_back(r);
    endtask

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    logic [28:0] rid;
    logic [2:0]  rcnt;
    int ent, nsig, ndec, lim, n_gen;
    bit big_o, burst_on;

    initial begin
        for (int e = 0; e < N_ENTRY; e++) begin
            tbl_cnt[e] = '0;
            for (int k = 0; k < N_SLOT; k++) slot_loaded[e][k] = 0;
        end
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < 10; i++) id_pool[i] = 29'($urandom);

        // count above four clamps; full span with both saturation directions
        add_load(5, 0, '0, 3'd7, 1'b1, 3'd0, 3'd7, 32'h7fff_ffff, 48'h7fff_ffff_ffff);
        add_load(5, 1, '0, 3'd7, 1'b1, 3'd0, 3'd7, 32'h8000_0000, 48'h8000_0000_0000);
        add_load(5, 2, '0, 3'd7, 1'b1, 3'd5, 3'd2, $urandom, 48'({$urandom, $urandom}));
        add_load(5, 3, '0, 3'd7, 1'b1, 3'd3, 3'd3, 32'd0, 48'd0);
        add_decode('0, '1, '1);
        add_decode('0, '0, '0);
        add_decode('0, {$urandom, $urandom}, {$urandom, $urandom});
        // little-endian entry at the top index and the widest identifier
        add_load(63, 0, '1, 3'd1, 1'b0, 3'd0, 3'd7, 32'h0001_0000, 48'd0);
        add_decode('1, 64'h0807_0605_0403_0201, 64'd1);
        add_decode('1, '1, {$urandom, $urandom});
        // duplicate identifier: higher entry wins
        add_load(10, 0, '0, 3'd1, 1'b0, 3'd2, 3'd4, 32'hffff_0000, 48'h0000_1234_0000);
        add_decode('0, 64'h1122_3344_5566_7788, 64'd2);
        // clearing the count empties the entry
        add_load(10, 0, '0, 3'd0, 1'b0, 3'd2, 3'd4, 32'hffff_0000, 48'h0);
        add_decode('0, 64'hdead_beef_cafe_f00d, 64'd3);
        add_decode(29'd12345, {$urandom, $urandom}, 64'd4);
        add_decode('1, {$urandom, $urandom}, 64'd5, 1);

        n_gen = pending_q.size();
        while (n_gen < 380) begin
            burst_on = (n_gen >= 150 && n_gen < 200);
            if (n_gen >= 250 && n_gen < 260 && $urandom_range(0, 3) == 0) begin
                add_decode(id_pool[$urandom_range(0, 9)], {$urandom, $urandom},
                           {$urandom, $urandom}, 1);
            end else if ($urandom_range(0, 9) < 7) begin
                // program a whole entry, then send frames for it
                ent   = $urandom_range(0, N_ENTRY - 1);
                nsig  = $urandom_range(1, 4);
                rid   = id_pool[$urandom_range(0, 9)];
                big_o = 1'($urandom);
                rcnt  = (nsig == 4) ? 3'($urandom_range(4, 7)) : 3'(nsig);
                for (int k = 0; k < nsig; k++)
                    add_load(ent, k, rid, rcnt, big_o, 3'($urandom), 3'($urandom),
                             rand_scale(), 48'({$urandom, $urandom}), burst_on);
                ndec = $urandom_range(1, 4);
                for (int j = 0; j < ndec; j++)
                    add_decode(rid, {$urandom, $urandom}, {$urandom, $urandom}, 0, burst_on);
            end else if ($urandom_range(0, 1) == 0) begin
                // stray load; count kept to loaded slots
                ent = $urandom_range(0, N_ENTRY - 1);
                nsig = $urandom_range(0, 3);
                slot_loaded[ent][nsig] = 1;
                lim  = ready_slots(ent);
                rcnt = 3'($urandom_range(0, 7));
                if ((rcnt > 3'd4 ? 4 : int'(rcnt)) > lim) rcnt = 3'(lim);
                add_load(ent, nsig, $urandom_range(0, 1) ? id_pool[$urandom_range(0, 9)]
                         : 29'($urandom), rcnt, 1'($urandom), 3'($urandom), 3'($urandom),
                         rand_scale(), 48'({$urandom, $urandom}), burst_on);
            end else begin
                add_decode($urandom_range(0, 1) ? id_pool[$urandom_range(0, 9)] : 29'($urandom),
                           {$urandom, $urandom}, {$urandom, $urandom}, 0, burst_on);
            end
            n_gen = pending_q.size();
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || cur_busy || decoded_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("covered %0d descriptor loads and %0d frames (%0d without a match)",
                 n_loads, n_decodes, n_nomatch);
        $display("checked %0d signal results, %0d of them clipped", n_results, n_sat);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
